### rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define MEXP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked property, checked through reset as well
`define MEXP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### rtl/mexp_pkg.sv
// types and constants for the modular exponentiation block
// no dependencies
package mexp_pkg;

    localparam int FIELD_W      = 32;
    localparam int MOD_BITS_DEF = 32;
    localparam int EXP_BITS_DEF = 32;

    // input beat
    typedef struct packed {
        logic [FIELD_W-1:0] base_value;
        logic [FIELD_W-1:0] exponent_value;
        logic [FIELD_W-1:0] modulus_value;
    } t_mexp_in;

    // output beat
    typedef struct packed {
        logic [FIELD_W-1:0] power_result;
        logic               modulus_zero;
    } t_mexp_out;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RED,
        S_STEP,
        S_MUL,
        S_SQR,
        S_FINISH
    } t_mexp_state;

    // operand selection for the multiplier
    typedef enum logic [1:0] {
        OP_RED,
        OP_MUL,
        OP_SQR
    } t_mexp_op;

endpackage

### rtl/mexp_mulmod.sv
// bit-serial modular multiplier: interleaved double-and-add, one multiplier bit a cycle
// depends on nothing but its parameters
module mexp_mulmod #(
    parameter int MOD_W = 32,
    parameter int BIT_W = 32,
    parameter int CNT_W = $clog2(BIT_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MOD_W-1:0] i_a,
    input  logic [BIT_W-1:0] i_b,
    input  logic [CNT_W-1:0] i_nbits,
    input  logic [MOD_W-1:0] i_m,
    output logic             o_done,
    output logic [MOD_W-1:0] o_prod
);

    logic [MOD_W-1:0] r_r, n_r;
    logic [MOD_W-1:0] r_a, n_a;
    logic [BIT_W-1:0] r_b, n_b;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [MOD_W+1:0] sum;
    logic [MOD_W+1:0] m1;
    logic [MOD_W+1:0] m2;
    logic [MOD_W+1:0] red;

    // one step: 2r + bit*a stays below 3m, so subtract 0, m or 2m
    always_comb begin
        m1  = (MOD_W+2)'(i_m);
        m2  = (MOD_W+2)'({i_m, 1'b0});
        sum = (MOD_W+2)'({r_r, 1'b0}) + (r_b[BIT_W-1] ? (MOD_W+2)'(r_a) : '0);
        if (sum >= m2) begin
            red = sum - m2;
        end else if (sum >= m1) begin
            red = sum - m1;
        end else begin
            red = sum;
        end
    end

    // load on start, then walk the multiplier bits msb first
    always_comb begin
        n_r    = r_r;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_r    = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_cnt  = i_nbits;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_r   = red[MOD_W-1:0];
            n_b   = {r_b[BIT_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_r   <= n_r;
        r_a   <= n_a;
        r_b   <= n_b;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_prod = r_r;

endmodule

### rtl/modular_exponentiation.sv
// top level: right-to-left square-and-multiply over a bit-serial modular multiplier
// depends on mexp_pkg and mexp_mulmod
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | i_in_valid, o_in_ready, i_in_data     | into block
//   out     | o_out_valid, i_out_ready, o_out_data  | out of block
//
// one item at a time; every modular product, the base reduction included, runs in the
// single double-and-add multiplier; scanning stops at the top set exponent bit
// a zero modulus is flagged as its beat is taken and skips the multiplier;
// synchronous active-low reset clears the sequencer
// the next beat is taken while a finished result waits in the output register
module modular_exponentiation #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF,
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mexp_pkg::t_mexp_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mexp_pkg::t_mexp_out o_out_data
);

    import mexp_pkg::*;

    localparam int BIT_W = (MOD_BITS > FIELD_W) ? MOD_BITS : FIELD_W;
    localparam int CNT_W = $clog2(BIT_W + 1);

    t_mexp_state r_state, n_state;
    t_mexp_op    op_sel;
    logic        mul_start;

    logic [FIELD_W-1:0]  r_base_raw;
    logic [MOD_BITS-1:0] r_mod;
    logic [EXP_BITS-1:0] r_exp;
    logic [MOD_BITS-1:0] r_base;
    logic [MOD_BITS-1:0] r_acc;
    logic                r_zero;
    logic                r_out_valid;
    t_mexp_out           r_out;

    logic [MOD_BITS+FIELD_W-1:0] mod_ext;
    logic [EXP_BITS+FIELD_W-1:0] exp_ext;
    logic [MOD_BITS+FIELD_W-1:0] acc_ext;

    logic                in_beat;
    logic                out_free;
    logic                mod_is_one;
    logic                exp_done;
    logic [MOD_BITS-1:0] acc_op;

    logic [MOD_BITS-1:0] mm_a;
    logic [BIT_W-1:0]    mm_b;
    logic [CNT_W-1:0]    mm_nbits;
    logic                mm_done;
    logic [MOD_BITS-1:0] mm_prod;

    // field masking to the configured widths
    assign mod_ext = (MOD_BITS+FIELD_W)'(i_in_data.modulus_value);
    assign exp_ext = (EXP_BITS+FIELD_W)'(i_in_data.exponent_value);
    assign acc_ext = (MOD_BITS+FIELD_W)'(r_acc);

    assign in_beat    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign mod_is_one = (r_mod == MOD_BITS'(1));
    assign exp_done   = (r_exp == '0);
    // the initial 1 reduces to 0 under modulus one
    assign acc_op     = mod_is_one ? '0 : r_acc;

    // operand selection for the multiplier
    always_comb begin
        case (op_sel)
            OP_RED: begin
                mm_a     = MOD_BITS'(1);
                mm_b     = BIT_W'(r_base_raw) << (BIT_W - FIELD_W);
                mm_nbits = CNT_W'(FIELD_W);
            end
            OP_MUL: begin
                mm_a     = acc_op;
                mm_b     = BIT_W'(r_base) << (BIT_W - MOD_BITS);
                mm_nbits = CNT_W'(MOD_BITS);
            end
            default: begin
                mm_a     = r_base;
                mm_b     = BIT_W'(r_base) << (BIT_W - MOD_BITS);
                mm_nbits = CNT_W'(MOD_BITS);
            end
        endcase
    end

    // sequencer: next state and multiplier launches
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        op_sel    = OP_SQR;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_mod == '0) begin
                    n_state = S_FINISH;
                end else begin
                    op_sel    = OP_RED;
                    mul_start = 1'b1;
                    n_state   = S_RED;
                end
            end
            S_RED: begin
                if (mm_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (exp_done) begin
                    n_state = S_FINISH;
                end else if (r_exp[0]) begin
                    op_sel    = OP_MUL;
                    mul_start = 1'b1;
                    n_state   = S_MUL;
                end else begin
                    op_sel    = OP_SQR;
                    mul_start = 1'b1;
                    n_state   = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    n_state = S_STEP;
                end
            end
            S_SQR: begin
                if (mm_done) begin
                    n_state = S_STEP;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_base_raw <= i_in_data.base_value;
            r_mod      <= mod_ext[MOD_BITS-1:0];
            r_exp      <= exp_ext[EXP_BITS-1:0];
            r_acc      <= MOD_BITS'(1);
            r_zero     <= (mod_ext[MOD_BITS-1:0] == '0);
        end
        if (r_state == S_RED && mm_done) begin
            r_base <= mm_prod;
        end
        // multiply retires the low exponent bit
        if (r_state == S_MUL && mm_done) begin
            r_acc    <= mm_prod;
            r_exp[0] <= 1'b0;
        end
        if (r_state == S_SQR && mm_done) begin
            r_base <= mm_prod;
            r_exp  <= r_exp >> 1;
        end
        if (r_state == S_FINISH && out_free) begin
            r_out.power_result <= r_zero ? '0 : acc_ext[FIELD_W-1:0];
            r_out.modulus_zero <= r_zero;
        end
    end

    mexp_mulmod #(
        .MOD_W (MOD_BITS),
        .BIT_W (BIT_W),
        .CNT_W (CNT_W)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_nbits (mm_nbits),
        .i_m     (r_mod),
        .o_done  (mm_done),
        .o_prod  (mm_prod)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/mexp_checker.sv
// port-level checks for the modular exponentiation block, bound to the top level
// depends on mexp_pkg and assert_macros.svh
`include "assert_macros.svh"

module mexp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mexp_pkg::t_mexp_out o_out_data
);

    import mexp_pkg::*;

    // result beat holds until taken
    `MEXP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)

    // stalled result keeps its payload
    `MEXP_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_data))

    // zero modulus always reports a zero result
    `MEXP_ASSERT(a_zero_mod, i_clk, i_rst_n, o_out_valid && o_out_data.modulus_zero |-> o_out_data.power_result == '0)

    // one item in flight: ready drops after an accepted beat
    `MEXP_ASSERT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

    // reset empties the output register
    `MEXP_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### verif/tb_modular_exponentiation.sv
// testbench for modular_exponentiation: directed corners, then random operand mixes
// predicts base^exponent mod modulus itself and checks every output beat in order
// depends on mexp_pkg and the modular_exponentiation rtl
`timescale 1ns / 1ps

module tb_modular_exponentiation;

    import mexp_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned PRINT_LIMIT = 20;
    localparam int unsigned SETTLE_CYCS = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_mexp_in  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_mexp_out o_out_data;

    // expected results, oldest first
    t_mexp_out   pending_powers[$];
    int unsigned mismatch_count;
    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned zero_mod_count;
    int unsigned zero_exp_count;
    int unsigned quiet_cycles;
    bit          no_idle;

    modular_exponentiation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // square-and-multiply from the low exponent bit, full 64-bit products
    function automatic t_mexp_out predict_power(input t_mexp_in beat);
        t_mexp_out  res;
        bit [63:0]  modulus;
        bit [63:0]  square;
        bit [63:0]  running;
        modulus = {32'd0, beat.modulus_value};
        res     = '0;
        if (modulus == 0) begin
            res.modulus_zero = 1'b1;
            return res;
        end
        square  = {32'd0, beat.base_value} % modulus;
        running = 64'd1;
        for (int i = 0; i < FIELD_W; i++) begin
            if (beat.exponent_value[i]) begin
                running = ((running % modulus) * square) % modulus;
            end
            square = (square * square) % modulus;
        end
        res.power_result = running[FIELD_W-1:0];
        return res;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        end
    endtask

    // drive one operand beat and record its expected result
    task automatic send_operands(input t_mexp_in beat);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        pending_powers.insert(pending_powers.size(), predict_power(beat));
        sent_count++;
        if (beat.modulus_value == 0) zero_mod_count++;
        if (beat.exponent_value == 0) zero_exp_count++;
    endtask

    task automatic send_triple(input logic [31:0] b, input logic [31:0] e,
                               input logic [31:0] m);
        t_mexp_in beat;
        beat.base_value     = b;
        beat.exponent_value = e;
        beat.modulus_value  = m;
        send_operands(beat);
    endtask

    // stop sending until every outstanding result is back
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    // operand mix: short exponents keep runs brief, full ones reach every bit
    function automatic t_mexp_in random_operands();
        t_mexp_in beat;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: beat.exponent_value = $urandom_range(0, 255);
            4, 5, 6, 7: beat.exponent_value = $urandom;
            8:          beat.exponent_value = $urandom_range(0, 1);
            default:    beat.exponent_value = 32'd1 << $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 19))
            0:          beat.modulus_value = '0;
            1, 2:       beat.modulus_value = $urandom_range(1, 3);
            3, 4:       beat.modulus_value = 32'hFFFF_FFFF - $urandom_range(0, 15);
            5:          beat.modulus_value = 32'd1 << $urandom_range(0, 31);
            default:    beat.modulus_value = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:          beat.base_value = '0;
            1:          beat.base_value = 32'd1;
            2:          beat.base_value = 32'hFFFF_FFFF;
            3:          beat.base_value = beat.modulus_value - 32'd1;
            default:    beat.base_value = $urandom;
        endcase
        return beat;
    endfunction

    // corners: zero modulus, zero exponent, modulus one, field extremes
    task automatic test_directed_corners();
        send_triple(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_triple(32'h0000_04D2, 32'h0000_0000, 32'h0000_0001);
        send_triple(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_triple(32'h0000_0005, 32'h0000_0003, 32'h0000_0001);
        send_triple(32'h0000_0000, 32'h0000_0000, 32'h0000_0007);
        send_triple(32'h0000_0000, 32'h0000_0005, 32'h0000_0007);
        send_triple(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8);
        send_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
        send_triple(32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0002);
        send_triple(32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF);
        send_triple(32'h0000_0007, 32'h8000_0000, 32'h0000_000D);
        send_triple(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        send_triple(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
        send_triple(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE);
        send_triple(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002);
        send_triple(32'h0000_0002, 32'h0000_001F, 32'h8000_0000);
        send_triple(32'h0000_0002, 32'h0000_001E, 32'h8000_0000);
        send_triple(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_mix(input int unsigned count);
        repeat (count) send_operands(random_operands());
    endtask

    // no sender gaps and no receiver stalls
    task automatic test_back_to_back(input int unsigned count);
        no_idle = 1'b1;
        repeat (count) send_operands(random_operands());
        hold_until_drained();
        no_idle = 1'b0;
    endtask

    // result side: random stalls, compare each beat with the oldest expectation
    initial begin
        int unsigned stall;
        t_mexp_out   want;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            checked_count++;
            if (pending_powers.size() == 0) begin
                report_mismatch("unexpected beat", o_out_data.power_result, '0);
            end else begin
                want = pending_powers.pop_front();
                if (o_out_data.power_result !== want.power_result) begin
                    report_mismatch("power_result", o_out_data.power_result,
                                    want.power_result);
                end
                if (o_out_data.modulus_zero !== want.modulus_zero) begin
                    report_mismatch("modulus_zero", 32'(o_out_data.modulus_zero),
                                    32'(want.modulus_zero));
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
            $display("modular_exponentiation verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        no_idle        = 1'b0;
        sent_count     = 0;
        zero_mod_count = 0;
        zero_exp_count = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        hold_until_drained();
        test_random_mix(120);
        hold_until_drained();
        test_back_to_back(30);
        test_random_mix(120);
        hold_until_drained();

        // let the block settle after the last beat
        repeat (SETTLE_CYCS) @(posedge i_clk);
        $display("covered %0d exponentiations (%0d checked), %0d zero moduli, %0d zero exponents",
                 sent_count, checked_count, zero_mod_count, zero_exp_count);
        $display("phases: corners, random stalls, back-to-back, drained pauses; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && pending_powers.size() == 0) begin
            $display("modular_exponentiation verification clean");
        end else begin
            $display("modular_exponentiation verification failed");
        end
        $finish;
    end

endmodule
